// ----- sv/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg: shared types and constants of the positional list
// Sizes, command and status codes, and the control request that is broadcast
// along the row of storage cells.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int EIDX_W   = 4;
  localparam int ECNT_W   = 5;

  localparam int S_DATA_W = 40;  // position, value
  localparam int M_DATA_W = 48;  // element, element_index, entry_count, pad

  typedef enum logic [CMD_W-1:0] {
    CMD_VIEW   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_SNAP   = 3'd3,
    CELL_SHIFT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ----- sv/pidl_cell.sv -----
// ----------------------------------------------------------------------------
// pidl_cell: one storage cell of the list
// Holds one entry and one view copy; takes neighbour data on insert, delete
// and view shift.
// ----------------------------------------------------------------------------
module pidl_cell (
  input  logic                           clk,
  input  pidl_pkg::cell_ctl_t            ctl,
  input  logic [pidl_pkg::IDX_W-1:0]     cell_idx,
  input  logic [pidl_pkg::VAL_W-1:0]     left_entry,
  input  logic [pidl_pkg::VAL_W-1:0]     right_entry,
  input  logic [pidl_pkg::VAL_W-1:0]     right_shadow,
  output logic [pidl_pkg::VAL_W-1:0]     entry,
  output logic [pidl_pkg::VAL_W-1:0]     shadow
);
  import pidl_pkg::*;

  logic [VAL_W-1:0] entry_next;
  logic [VAL_W-1:0] shadow_next;

  always_comb begin
    entry_next  = entry;
    shadow_next = shadow;
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (cell_idx == ctl.pos) begin
          entry_next = ctl.value;
        end else if (cell_idx > ctl.pos) begin
          entry_next = left_entry;
        end
      end
      CELL_DELETE: begin
        if (cell_idx >= ctl.pos) begin
          entry_next = right_entry;
        end
      end
      CELL_SNAP: begin
        shadow_next = entry;
      end
      CELL_SHIFT: begin
        shadow_next = right_shadow;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry  <= entry_next;
    shadow <= shadow_next;
  end

endmodule

// ----- sv/positional_insert_delete_list_core.sv -----
// Results: insert, delete and refused commands give their one result in the cycle
//   after the request is accepted; a view first snapshots the row into the view
//   copies, then streams one result per cycle while the receiver takes them.
// Input: one request per cycle for insert and delete while the result is free;
//   a view holds the input until its last entry is out (single view copy chain).
// Reset (rst, synchronous, active high) empties the list and drops any result.
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core: packed list with insert/delete at index
// A row of cells stores the entries; insert and delete shift the whole row at
// once, a view snapshots the row and streams it out through cell zero.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] position, [39:8] value
  input  logic [pidl_pkg::S_DATA_W-1:0]     s_tdata,
  // [1:0] command
  input  logic [pidl_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] element, [35:32] element_index, [40:36] entry_count, [47:41] zero
  output logic [pidl_pkg::M_DATA_W-1:0]     m_tdata,
  // [1:0] status
  output logic [pidl_pkg::STATUS_W-1:0]     m_tuser,
  output logic                              m_tlast
);
  import pidl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_VIEW = 2'b10
  } state_t;

  // Control state
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] view_idx, view_idx_next;

  // Result register
  status_t           out_status, status_next;
  logic [VAL_W-1:0]  out_element, element_next;
  logic [EIDX_W-1:0] out_index, index_next;
  logic [ECNT_W-1:0] out_count;
  logic              out_last, last_next;
  logic              load_out;

  // Request decode
  logic             out_free;
  logic             accept;
  cmd_t             cmd;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_value;
  logic [CMP_W-1:0] pos_cmp, count_cmp;
  logic [IDX_W-1:0] ins_pos;
  logic             is_full;
  logic             view_last;

  cell_ctl_t        ctl;
  logic [VAL_W-1:0] entry_q  [CAPACITY];
  logic [VAL_W-1:0] shadow_q [CAPACITY];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tuser);
  assign in_pos    = s_tdata[POS_W-1:0];
  assign in_value  = s_tdata[POS_W +: VAL_W];
  assign pos_cmp   = CMP_W'(in_pos);
  assign count_cmp = CMP_W'(count);
  assign is_full   = (count == CNT_W'(CAPACITY));
  // Clamp an insert past the end onto the append slot
  assign ins_pos   = (pos_cmp > count_cmp) ? IDX_W'(count) : IDX_W'(in_pos);
  assign view_last = ((CNT_W'(view_idx) + CNT_W'(1)) == count);

  always_comb begin
    state_next    = state;
    count_next    = count;
    view_idx_next = view_idx;
    load_out      = 1'b0;
    status_next   = ST_OK;
    element_next  = '0;
    index_next    = '0;
    last_next     = 1'b1;
    ctl.op        = CELL_HOLD;
    ctl.pos       = IDX_W'(in_pos);
    ctl.value     = in_value;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_VIEW: begin
              if (count == '0) begin
                load_out    = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                // Snapshot the row, then stream it out from cell zero
                ctl.op        = CELL_SNAP;
                view_idx_next = '0;
                state_next    = S_VIEW;
              end
            end
            CMD_INSERT: begin
              load_out = 1'b1;
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                ctl.op     = CELL_INSERT;
                ctl.pos    = ins_pos;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              load_out = 1'b1;
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (pos_cmp >= count_cmp) begin
                status_next = ST_BADPOS;
              end else begin
                ctl.op     = CELL_DELETE;
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              // Unused command: drop without a result
            end
          endcase
        end
      end
      S_VIEW: begin
        if (out_free) begin
          load_out      = 1'b1;
          element_next  = shadow_q[0];
          index_next    = EIDX_W'(view_idx);
          last_next     = view_last;
          ctl.op        = CELL_SHIFT;
          view_idx_next = view_idx + IDX_W'(1);
          if (view_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Row of storage cells; the ends see zero from beyond the row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_entry;
    logic [VAL_W-1:0] right_entry;
    logic [VAL_W-1:0] right_shadow;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_inner_l
      assign left_entry = entry_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right_entry  = '0;
      assign right_shadow = '0;
    end else begin : g_inner_r
      assign right_entry  = entry_q[i+1];
      assign right_shadow = shadow_q[i+1];
    end

    pidl_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .cell_idx     (IDX_W'(i)),
      .left_entry   (left_entry),
      .right_entry  (right_entry),
      .right_shadow (right_shadow),
      .entry        (entry_q[i]),
      .shadow       (shadow_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      view_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      view_idx <= view_idx_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next result is loaded
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= status_next;
      out_element <= element_next;
      out_index   <= index_next;
      out_count   <= ECNT_W'(count_next);
      out_last    <= last_next;
    end
  end

  assign m_tdata = {(M_DATA_W - VAL_W - EIDX_W - ECNT_W)'(0), out_count, out_index,
                    out_element};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_view_blocks_input : assert property (@(posedge clk) disable iff (rst)
    (state == S_VIEW) |-> !s_tready)
    else $error("request taken during a view");

  a_view_idx_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_VIEW) |-> (CNT_W'(view_idx) < count))
    else $error("view index past entry count");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_INSERT && !is_full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the list");
`endif

endmodule

// ----- tb/pidl_list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidl_list_checker: scoreboard for the positional list core
// Watches both stream channels, keeps a shadow copy of the list, works out
// the results owed for every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module pidl_list_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [pidl_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [pidl_pkg::CMD_W-1:0]      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [pidl_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic [pidl_pkg::STATUS_W-1:0]   m_tuser,
  input  logic                            m_tlast,
  output int                              fault_total,
  output int                              results_owed
);
  import pidl_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [VAL_W-1:0]    element;
    logic [EIDX_W-1:0]   elem_idx;
    logic [ECNT_W-1:0]   entry_count;
    logic                last;
  } list_result_t;

  logic [VAL_W-1:0] shadow_vals [CAPACITY];
  int unsigned      shadow_len;
  list_result_t     owed_results [$];
  int               faults;

  initial begin
    fault_total  = 0;
    results_owed = 0;
    faults       = 0;
    shadow_len   = 0;
  end

  function automatic void owe_result(status_t st, logic [VAL_W-1:0] elem,
                                     int unsigned idx, logic is_last);
    list_result_t r;
    r.status      = st;
    r.element     = elem;
    r.elem_idx    = idx[EIDX_W-1:0];
    r.entry_count = shadow_len[ECNT_W-1:0];
    r.last        = is_last;
    owed_results.push_back(r);
  endfunction

  // Apply one command to the shadow list and queue the results it owes
  function automatic void apply_list_command(cmd_t cmd, logic [POS_W-1:0] pos,
                                             logic [VAL_W-1:0] val);
    int unsigned slot;
    slot = pos;
    case (cmd)
      CMD_VIEW: begin
        if (shadow_len == 0) begin
          owe_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_len; i++)
            owe_result(ST_OK, shadow_vals[i], i, (i + 1 == shadow_len));
        end
      end
      CMD_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          owe_result(ST_FULL, '0, 0, 1'b1);
        end else begin
          if (slot > shadow_len) slot = shadow_len;
          for (int unsigned i = shadow_len; i > slot; i--)
            shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[slot] = val;
          shadow_len++;
          owe_result(ST_OK, '0, 0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (shadow_len == 0) begin
          owe_result(ST_EMPTY, '0, 0, 1'b1);
        end else if (slot >= shadow_len) begin
          owe_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = slot; i + 1 < shadow_len; i++)
            shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
          owe_result(ST_OK, '0, 0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    list_result_t seen;
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      owed_results.delete();
    end else begin
      // Results leave before the request of this edge can owe any
      if (m_tvalid && m_tready) begin
        seen.status      = status_t'(m_tuser);
        seen.element     = m_tdata[31:0];
        seen.elem_idx    = m_tdata[35:32];
        seen.entry_count = m_tdata[40:36];
        seen.last        = m_tlast;
        if (owed_results.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: unexpected result status=%0d element=%h idx=%0d count=%0d last=%b",
                     $time, m_tuser, seen.element, seen.elem_idx, seen.entry_count,
                     seen.last);
        end else begin
          want = owed_results.pop_front();
          if (seen.status !== want.status || seen.element !== want.element ||
              seen.elem_idx !== want.elem_idx || seen.entry_count !== want.entry_count ||
              seen.last !== want.last) begin
            faults++;
            if (faults <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected status=%0d element=%h idx=%0d count=%0d last=%b",
                       want.status, want.element, want.elem_idx, want.entry_count,
                       want.last);
              $display("  actual   status=%0d element=%h idx=%0d count=%0d last=%b",
                       m_tuser, seen.element, seen.elem_idx, seen.entry_count,
                       seen.last);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_list_command(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[39:8]);
    end
    fault_total  <= faults;
    results_owed <= owed_results.size();
  end

endmodule

// ----- tb/tb_positional_insert_delete_list_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_list_core: regression for the positional list
// Drives directed and random insert, delete and view requests with random
// gaps and back-pressure; a separate scoreboard predicts and checks results.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_list_core;
  import pidl_pkg::*;

  localparam int RANDOM_REQUESTS = 232;
  localparam int HOLD_OFF_CYCLES = 80;   // long receiver stall to fill the core
  localparam int STALL_LIMIT     = 1000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [7:0] position, [39:8] value
  logic [S_DATA_W-1:0]   s_tdata = '0;
  // [1:0] command
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [31:0] element, [35:32] element_index, [40:36] entry_count, [47:41] zero
  logic [M_DATA_W-1:0]   m_tdata;
  // [1:0] status
  logic [STATUS_W-1:0]   m_tuser;
  logic                  m_tlast;

  int  fault_total;
  int  results_owed;
  int  quiet_cycles = 0;
  bit  steady       = 1'b0;   // both sides run without idling
  bit  hold_off_req = 1'b0;   // ask the receiver for one long stall

  positional_insert_delete_list_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  pidl_list_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fault_total  (fault_total),
    .results_owed (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("positional_insert_delete_list_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Offer one request and hold it until the core takes it. Valid is only
  // lowered for an idle gap, so back-to-back requests keep it high.
  task automatic send_request(input cmd_t cmd, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    if (!steady) begin
      while ($urandom_range(0, 99) < 15) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] extremes [4];
    extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    if ($urandom_range(0, 99) < 20) return extremes[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    // Mostly near the live range of the list, sometimes anywhere
    if ($urandom_range(0, 99) < 70) return POS_W'($urandom_range(0, CAPACITY + 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int   sent;
    int   roll;
    cmd_t cmd;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: refusals on an empty list first
    send_request(CMD_VIEW,   8'd0,   pick_value());
    send_request(CMD_DELETE, 8'd0,   pick_value());
    send_request(CMD_DELETE, 8'd255, 32'hffff_ffff);
    // Inserts at the head, past the end (clamped) and in the middle
    send_request(CMD_INSERT, 8'd0,   32'h7fff_ffff);
    send_request(CMD_INSERT, 8'd255, 32'h8000_0000);
    send_request(CMD_INSERT, 8'd1,   32'hffff_ffff);
    send_request(CMD_INSERT, 8'd0,   32'h0000_0000);
    send_request(CMD_VIEW,   8'd0,   32'h0);
    // Delete at the count and far past it, then a real delete
    send_request(CMD_DELETE, 8'd4,   32'h0);
    send_request(CMD_DELETE, 8'd255, 32'h0);
    send_request(CMD_DELETE, 8'd0,   32'h0);
    // Unused command code: dropped without a result
    send_request(CMD_NONE,   8'd7,   32'h1234_5678);
    // Fill the list, refuse one more, view it whole, trim the tail
    repeat (CAPACITY - 3) send_request(CMD_INSERT, pick_position(), pick_value());
    send_request(CMD_INSERT, 8'd3,   32'h5555_aaaa);
    send_request(CMD_VIEW,   8'd0,   32'h0);
    send_request(CMD_DELETE, 8'd15,  32'h0);

    // Random: alternate insert-heavy and delete-heavy phases so the list
    // swings between full and empty
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      steady = (sent >= 180 && sent < 230);
      if (sent == 90) hold_off_req = 1'b1;
      roll = $urandom_range(0, 99);
      if (((sent / 40) % 2) == 0)
        cmd = (roll < 55) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
              (roll < 95) ? CMD_VIEW : CMD_NONE;
      else
        cmd = (roll < 25) ? CMD_INSERT : (roll < 70) ? CMD_DELETE :
              (roll < 93) ? CMD_VIEW : CMD_NONE;
      send_request(cmd, pick_position(), pick_value());
      sent++;
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    // Drain: let the scoreboard count settle, wait for every owed result,
    // then let the pipeline settle
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_total == 0 && results_owed == 0) begin
      $display("positional_insert_delete_list_core regression: pass");
    end else begin
      $display("positional_insert_delete_list_core regression: fail");
    end
    $finish;
  end

endmodule
